@@ hw/rtl/lrs_pkg.sv @@
// shared command codes for the line raster stepper
package lrs_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

endpackage

@@ hw/rtl/line_raster_stepper.sv @@
// line raster stepper: endpoint setup, per-pixel error stepping and a two-beat result buffer
//
// A start beat (tuser = start) loads two endpoints and gives no result; each step beat then
// gives one pixel, and the final endpoint comes out with tlast high. A step while no line is
// active gives nothing. One beat is taken every cycle: the endpoint setup is a single pass of
// add and compare logic from the input into the line registers, and each step is a single
// pass from the line registers into a two-entry result buffer, so a pixel sits in the buffer
// in the cycle after its step beat is taken and the input only stalls when both buffer entries
// hold unread pixels.
module line_raster_stepper #(
   parameter int COORD_BITS = 16,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_a, y_a, x_b, y_b
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  lrs_pkg::cmd_type         req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x, pixel_y
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);
   import lrs_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int TB = COORD_BITS + 1;
   localparam int EB = COORD_BITS + 4;

   typedef struct packed {
      logic [CB-1:0] pixel_x;
      logic [CB-1:0] pixel_y;
      logic          last;
   } slot_type;

   // line state
   logic                 busy_ff, busy_in;
   logic                 steep_ff, steep_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in;
   logic signed [CB-1:0] cur_y_ff, cur_y_in;
   logic signed [CB-1:0] major_end_ff, major_end_in;
   logic                 minor_dir_neg_ff, minor_dir_neg_in;
   logic [TB-1:0]        twice_minor_ff, twice_minor_in;
   logic [TB-1:0]        twice_major_ff, twice_major_in;
   logic signed [EB-1:0] err_acc_ff, err_acc_in;

   // result buffer
   slot_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic accept, push, pop;

   // endpoint setup
   logic signed [CB-1:0] x_a, y_a, x_b, y_b;
   logic signed [CB:0]   dx, dy, adx_wide, ady_wide;
   logic [CB-1:0]        adx, ady, dmaj, dmin;
   logic signed [CB-1:0] maj_a, maj_b, min_a, min_b, m1, n1, m2, n2;
   logic                 setup_steep, swap_ends;
   logic signed [EB-1:0] err_start;

   // stepping
   logic signed [CB-1:0] maj, mnr, maj_next, mnr_next;
   logic                 fin, err_ge;
   logic [EB-1:0]        err_sub;
   logic signed [EB-1:0] err_next;

   assign x_a = req_tdata[CB-1:0];
   assign y_a = req_tdata[2*CB-1:CB];
   assign x_b = req_tdata[3*CB-1:2*CB];
   assign y_b = req_tdata[4*CB-1:3*CB];

   always_comb begin
      dx = {x_b[CB-1], x_b} - {x_a[CB-1], x_a};
      dy = {y_b[CB-1], y_b} - {y_a[CB-1], y_a};
      adx_wide = dx[CB] ? -dx : dx;
      ady_wide = dy[CB] ? -dy : dy;
      adx = adx_wide[CB-1:0];
      ady = ady_wide[CB-1:0];
      setup_steep = ady > adx;
      maj_a = setup_steep ? y_a : x_a;
      maj_b = setup_steep ? y_b : x_b;
      min_a = setup_steep ? x_a : y_a;
      min_b = setup_steep ? x_b : y_b;
      dmaj  = setup_steep ? ady : adx;
      dmin  = setup_steep ? adx : ady;
      swap_ends = maj_a > maj_b;
      m1 = swap_ends ? maj_b : maj_a;
      n1 = swap_ends ? min_b : min_a;
      m2 = swap_ends ? maj_a : maj_b;
      n2 = swap_ends ? min_a : min_b;
      err_start = {3'b000, dmin, 1'b0} - {4'b0000, dmaj};
   end

   always_comb begin
      maj = steep_ff ? cur_y_ff : cur_x_ff;
      mnr = steep_ff ? cur_x_ff : cur_y_ff;
      fin = maj >= major_end_ff;
      err_ge = !err_acc_ff[EB-1];
      if (!err_ge) begin
         mnr_next = mnr;
      end else if (minor_dir_neg_ff) begin
         mnr_next = mnr - CB'(1);
      end else begin
         mnr_next = mnr + CB'(1);
      end
      err_sub = err_ge ? {3'b000, twice_major_ff} : '0;
      err_next = err_acc_ff - err_sub + {3'b000, twice_minor_ff};
      maj_next = maj + CB'(1);
   end

   assign accept = req_tvalid && req_tready;
   assign push   = accept && (req_tuser == CMD_STEP) && busy_ff;
   assign pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      busy_in          = busy_ff;
      steep_in         = steep_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      major_end_in     = major_end_ff;
      minor_dir_neg_in = minor_dir_neg_ff;
      twice_minor_in   = twice_minor_ff;
      twice_major_in   = twice_major_ff;
      err_acc_in       = err_acc_ff;
      if (accept) begin
         unique case (req_tuser)
            CMD_START: begin
               busy_in          = 1'b1;
               steep_in         = setup_steep;
               cur_x_in         = setup_steep ? n1 : m1;
               cur_y_in         = setup_steep ? m1 : n1;
               major_end_in     = m2;
               minor_dir_neg_in = !(n1 < n2);
               twice_minor_in   = {dmin, 1'b0};
               twice_major_in   = {dmaj, 1'b0};
               err_acc_in       = err_start;
            end
            CMD_STEP: begin
               if (busy_ff) begin
                  if (fin) begin
                     busy_in = 1'b0;
                  end else begin
                     err_acc_in = err_next;
                     cur_x_in   = steep_ff ? mnr_next : maj_next;
                     cur_y_in   = steep_ff ? maj_next : mnr_next;
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         steep_ff         <= 1'b0;
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         major_end_ff     <= '0;
         minor_dir_neg_ff <= 1'b0;
         twice_minor_ff   <= '0;
         twice_major_ff   <= '0;
         err_acc_ff       <= '0;
         wr_ptr_ff        <= 1'b0;
         rd_ptr_ff        <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         busy_ff          <= busy_in;
         steep_ff         <= steep_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         major_end_ff     <= major_end_in;
         minor_dir_neg_ff <= minor_dir_neg_in;
         twice_minor_ff   <= twice_minor_in;
         twice_major_ff   <= twice_major_in;
         err_acc_ff       <= err_acc_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{pixel_x: cur_x_ff, pixel_y: cur_y_ff, last: fin};
      end
   end

   assign req_tready = count_ff != 2'd2;
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = RSP_DATA_BITS'({slot_ff[rd_ptr_ff].pixel_y, slot_ff[rd_ptr_ff].pixel_x});
   assign rsp_tlast  = slot_ff[rd_ptr_ff].last;

endmodule

@@ hw/rtl/lrs_checker.sv @@
// port-level checks for the line raster stepper and their bind
module lrs_checker #(
   parameter int COORD_BITS = 16,
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   // cmd
   input lrs_pkg::cmd_type         req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   // pixel_x, pixel_y
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);
   import lrs_pkg::*;

   // buffer comes out of reset empty and open
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("result buffer not empty after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // input only stalls while results are waiting
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // a start beat never produces a result
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && req_tready && req_tuser == CMD_START |=> !rsp_tvalid)
      else $error("result appeared after a start beat");

endmodule

bind line_raster_stepper lrs_checker #(.COORD_BITS(COORD_BITS)) u_lrs_checker (.*);

@@ test/tb_line_raster_stepper.sv @@
// testbench for line_raster_stepper: directed and random lines against a line-stepping predictor
module tb_line_raster_stepper;
   import lrs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int BEAT_TARGET = 625;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NONE,
      CHK_PIXEL
   } row_check_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } pixel_type;

   typedef struct {
      cmd_type       cmd;
      logic [63:0]   ends;
      row_check_type chk;
      pixel_type     pix;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // x_a, y_a, x_b, y_b
   logic [63:0] req_tdata = '0;
   // cmd
   cmd_type     req_tuser = CMD_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // pixel_x, pixel_y
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   pixel_type pending_pixels[$];
   row_type   directed_rows[$];
   int        err_count = 0;
   int        beats_sent = 0;
   int        quiet_cycles = 0;
   bit        hold_rsp = 1'b0;

   // line state of the predictor
   bit                 ln_busy = 1'b0;
   bit                 ln_steep = 1'b0;
   bit                 ln_dir_neg = 1'b0;
   logic signed [15:0] ln_x = '0;
   logic signed [15:0] ln_y = '0;
   logic signed [15:0] ln_end = '0;
   longint             ln_twice_minor = 0;
   longint             ln_twice_major = 0;
   longint             ln_err = 0;

   line_raster_stepper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void line_advance(input cmd_type cmd, input logic [63:0] ends,
                                        output bit emitted, output pixel_type pix);
      logic signed [15:0] xa, ya, xb, yb, maj, mnr;
      longint la_x, la_y, lb_x, lb_y, adx, ady, dmaj, dmin, ma, mb, na, nb, t;
      emitted = 1'b0;
      pix = '0;
      if (cmd == CMD_START) begin
         {yb, xb, ya, xa} = ends;
         la_x = xa;
         la_y = ya;
         lb_x = xb;
         lb_y = yb;
         adx = (la_x > lb_x) ? la_x - lb_x : lb_x - la_x;
         ady = (la_y > lb_y) ? la_y - lb_y : lb_y - la_y;
         ln_steep = ady > adx;
         if (ln_steep) begin
            ma = la_y; mb = lb_y; na = la_x; nb = lb_x; dmaj = ady; dmin = adx;
         end else begin
            ma = la_x; mb = lb_x; na = la_y; nb = lb_y; dmaj = adx; dmin = ady;
         end
         if (ma > mb) begin
            t = ma; ma = mb; mb = t;
            t = na; na = nb; nb = t;
         end
         ln_dir_neg = !(na < nb);
         ln_end = 16'(mb);
         ln_twice_minor = 2 * dmin;
         ln_twice_major = 2 * dmaj;
         ln_err = ln_twice_minor - dmaj;
         ln_x = ln_steep ? 16'(na) : 16'(ma);
         ln_y = ln_steep ? 16'(ma) : 16'(na);
         ln_busy = 1'b1;
      end else if (ln_busy) begin
         maj = ln_steep ? ln_y : ln_x;
         mnr = ln_steep ? ln_x : ln_y;
         emitted = 1'b1;
         pix.x = ln_x;
         pix.y = ln_y;
         pix.last = (maj >= ln_end);
         if (pix.last) begin
            ln_busy = 1'b0;
         end else begin
            if (ln_err >= 0) begin
               mnr = ln_dir_neg ? mnr - 16'sd1 : mnr + 16'sd1;
               ln_err -= ln_twice_major;
            end
            ln_err += ln_twice_minor;
            maj = maj + 16'sd1;
            ln_x = ln_steep ? mnr : maj;
            ln_y = ln_steep ? maj : mnr;
         end
      end
   endfunction

   function automatic logic [63:0] pack_ends(input int xa, input int ya, input int xb,
                                             input int yb);
      return {16'(yb), 16'(xb), 16'(ya), 16'(xa)};
   endfunction

   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return -32768 + int'($urandom_range(0, 15));
      if (r < 30) return 32767 - int'($urandom_range(0, 15));
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int other_end(input int a, input int d);
      return (a + d > 32767 || a + d < -32768) ? a - d : a + d;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      err_count++;
   endtask

   task automatic add_row(input cmd_type cmd, input int xa, input int ya, input int xb,
                          input int yb, input row_check_type chk, input int px, input int py,
                          input bit lst);
      row_type row;
      row.cmd = cmd;
      row.ends = pack_ends(xa, ya, xb, yb);
      row.chk = chk;
      row.pix.x = 16'(px);
      row.pix.y = 16'(py);
      row.pix.last = lst;
      directed_rows.push_back(row);
   endtask

   // valid stays high after a beat so that a zero gap never lowers and raises it in one step
   task automatic send_beat(input cmd_type cmd, input logic [63:0] ends, input int gap,
                            input row_check_type chk, input pixel_type typed);
      bit        emitted;
      pixel_type pix;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= ends;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      line_advance(cmd, ends, emitted, pix);
      case (chk)
         CHK_PREDICT: if (emitted) pending_pixels.push_back(pix);
         CHK_PIXEL: pending_pixels.push_back(typed);
         default: ;
      endcase
   endtask

   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // receiver
   initial begin
      int        stall;
      int        rsp_count;
      pixel_type got, want;
      rsp_count = 0;
      @(negedge reset);
      forever begin
         stall = ((rsp_count % 64) < 16) ? 0 : $urandom_range(0, 5);
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
         got.x = rsp_tdata[15:0];
         got.y = rsp_tdata[31:16];
         got.last = rsp_tlast;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none pending",
                                      $signed(got.x), $signed(got.y), got.last));
         end else begin
            want = pending_pixels.pop_front();
            if (got.x != want.x)
               report_mismatch($sformatf("pixel_x %0d, want %0d",
                                         $signed(got.x), $signed(want.x)));
            if (got.y != want.y)
               report_mismatch($sformatf("pixel_y %0d, want %0d",
                                         $signed(got.y), $signed(want.y)));
            if (got.last != want.last)
               report_mismatch($sformatf("last %0b, want %0b at (%0d,%0d)", got.last,
                                         want.last, $signed(want.x), $signed(want.y)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_line_raster_stepper: FAIL");
            $finish;
         end
      end
   end

   // sender
   initial begin
      int        xa, ya, xb, yb, dx, dy, span, n_steps, kind, r, gap;
      bit        steady, hold_done, drained, long_line;
      pixel_type no_pix;
      no_pix = '0;
      hold_done = 1'b0;
      drained = 1'b0;

      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NONE, 0, 0, 0);
      add_row(CMD_START, 0, 0, 0, 0, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 1);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NONE, 0, 0, 0);
      add_row(CMD_START, -32768, -32768, 32767, 32767, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, -32768, -32768, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_START, 0, 32767, 0, -32768, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, -32768, 0);
      add_row(CMD_START, 32767, -32768, -32768, 32767, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, -32768, 32767, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_START, 0, 0, 3, 1, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 3, 1, 1);
      add_row(CMD_START, 0, 0, -2, 5, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_START, 32765, 32767, 32767, 32767, CHK_NONE, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT, 0, 0, 0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 32767, 32767, 1);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NONE, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].ends, $urandom_range(0, 5),
                   directed_rows[i].chk, directed_rows[i].pix);
      drain_pixels();

      while (beats_sent < BEAT_TARGET) begin
         if (!drained && beats_sent > 450) begin
            drain_pixels();
            drained = 1'b1;
         end
         long_line = 1'b0;
         if (!hold_done && beats_sent > 250) begin
            hold_rsp = 1'b1;
            hold_done = 1'b1;
            long_line = 1'b1;
         end
         steady = long_line || ($urandom_range(0, 7) == 0);
         kind = long_line ? 0 : $urandom_range(0, 99);
         if (kind < 75) begin
            span = ($urandom_range(0, 9) == 0) ? 80 : 12;
            xa = pick_coord();
            ya = pick_coord();
            dx = long_line ? 60 : int'($urandom_range(0, 2 * span)) - span;
            dy = long_line ? int'($urandom_range(0, 20)) :
                             int'($urandom_range(0, 2 * span)) - span;
            xb = other_end(xa, dx);
            yb = other_end(ya, dy);
            n_steps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                       (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy)) + 1;
            r = $urandom_range(0, 99);
            if (!long_line && r < 15)
               n_steps += $urandom_range(1, 3);
            else if (!long_line && r < 30)
               n_steps = $urandom_range(0, n_steps - 1);
         end else if (kind < 85) begin
            xa = pick_coord();
            ya = pick_coord();
            xb = pick_coord();
            yb = pick_coord();
            n_steps = $urandom_range(0, 8);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               gap = steady ? 0 : $urandom_range(0, 5);
               send_beat(cmd_type'($urandom_range(0, 1)), {$urandom, $urandom}, gap,
                         CHK_PREDICT, no_pix);
            end
            continue;
         end
         gap = steady ? 0 : $urandom_range(0, 5);
         send_beat(CMD_START, pack_ends(xa, ya, xb, yb), gap, CHK_PREDICT, no_pix);
         repeat (n_steps) begin
            gap = steady ? 0 : $urandom_range(0, 5);
            send_beat(CMD_STEP, {$urandom, $urandom}, gap, CHK_PREDICT, no_pix);
         end
      end

      drain_pixels();
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("tb_line_raster_stepper: PASS");
      else
         $display("tb_line_raster_stepper: FAIL");
      $finish;
   end

endmodule
